// ----- design/lev_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Levenshtein automaton step: shared types and constants
// Sizes of the position set, the image and the stream layouts.
// ---------------------------------------------------------------------------
package lev_pkg;

   localparam int MaxWord   = 64;
   localparam int MaxEdits  = 3;
   localparam int Span      = 2 * MaxEdits + 1;
   localparam int ImgSpan   = 3 * MaxEdits + 3;
   localparam int EditSpan  = MaxEdits + 1;
   localparam int SetBits   = Span * EditSpan;
   localparam int ImgBits   = ImgSpan * EditSpan;
   localparam int AddrW     = $clog2(MaxWord);
   localparam int CpW       = 21;
   localparam int BaseW     = 7;
   localparam int OffW      = $clog2(ImgSpan + 1);
   localparam int EditW     = $clog2(EditSpan + 1);
   localparam int PosW      = $clog2(Span);

   localparam logic [1:0] CMD_LOAD    = 2'd0;
   localparam logic [1:0] CMD_RESTART = 2'd1;
   localparam logic [1:0] CMD_FEED    = 2'd2;

   localparam logic CSR_MAX_EDITS   = 1'b0;
   localparam logic CSR_WORD_LENGTH = 1'b1;

endpackage

// ----- design/levenshtein_automaton_step_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Levenshtein automaton step core
// Holds a pattern and a position set; each letter beat steps the automaton.
// ---------------------------------------------------------------------------
// Sequence: load, restart, a letter to a dead automaton or any other command go through
// the status scan of every position and the output state; a live letter first reads,
// per offset, each window slot (S_READ then S_STEP) and walks every edit through the
// transition unit, then prunes each image entry, shifts, and goes on to status and output.
// Throughput: one beat at a time; a held status beat stalls the next one in its output
// cycle. Reset: synchronous; only (0,0), base 0.
module levenshtein_automaton_step_core
   import lev_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command[1:0], char_index[7:2], codepoint[28:8], zero pad [31:29]
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // alive[0], accepting[1], base_position[8:2], zero pad [15:9]
   output logic [15:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [6:0]  csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_STEP, S_PRUNE, S_SHIFT, S_STAT, S_OUT
   } state_type;

   state_type            state_ff;
   logic [1:0]           nmax_ff;
   logic [BaseW-1:0]     wlen_ff;
   logic [SetBits-1:0]   set_ff;
   logic [ImgBits-1:0]   img_ff, keep_ff;
   logic [BaseW-1:0]     base_ff;
   logic                 dead_ff;
   logic [CpW-1:0]       letter_ff;
   logic [PosW-1:0]      po_ff;      // current position offset
   logic [EditW-1:0]     pe_ff;      // current position edit
   logic [OffW-1:0]      ko_ff;
   logic [EditW-1:0]     ke_ff;
   logic [EditW-1:0]     wk_ff;      // window slot being read
   logic [Span-1:0]      chi_ff;     // characteristic bits of the window
   logic                 acc_ff;
   logic                 rsp_valid_ff;
   logic [15:0]          rsp_data_ff;
   logic [CpW-1:0]       ram [MaxWord];
   logic [CpW-1:0]       rd_ff;
   logic [AddrW-1:0]     rd_addr;
   logic [BaseW:0]       win_p;

   logic [1:0]  cmd;
   logic [AddrW-1:0] cidx;
   logic [CpW-1:0] cp;
   assign cmd  = req_tdata[1:0];
   assign cidx = req_tdata[7:2];
   assign cp   = req_tdata[28:8];

   logic [EditW-1:0] n_eff;
   logic [BaseW-1:0] w_eff;
   assign n_eff = (nmax_ff > 2'(MaxEdits)) ? EditW'(MaxEdits) : EditW'(nmax_ff);
   assign w_eff = (wlen_ff > BaseW'(MaxWord)) ? BaseW'(MaxWord) : wlen_ff;

   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Window slot wk_ff of position (po_ff) sits at base+po+wk.
   assign win_p   = {1'b0, base_ff} + (BaseW+1)'(po_ff) + (BaseW+1)'(wk_ff);
   assign rd_addr = win_p[AddrW-1:0];

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready && cmd == CMD_LOAD)
         ram[cidx] <= cp;
      rd_ff <= ram[rd_addr];
   end

   // Shared transition unit: one position, its window bits, into the image.
   function automatic logic [ImgBits-1:0] step_pos(
      input logic [ImgBits-1:0] img, input logic [PosW-1:0] o,
      input logic [EditW-1:0] e, input logic [Span-1:0] chi,
      input logic [BaseW-1:0] base, input logic [BaseW-1:0] w,
      input logic [EditW-1:0] n);
      logic [ImgBits-1:0] r;
      logic [BaseW:0] p, rem;
      logic [EditW:0] rl;
      logic found;
      r = img;
      p = {1'b0, base} + (BaseW+1)'(o);
      found = 1'b0;
      if (e >= n) begin
         if (chi[0]) r[(int'(o) + 1) * EditSpan + int'(e)] = 1'b1;
      end else begin
         rl = '0;
         if (p < (BaseW+1)'(w)) begin
            rem = (BaseW+1)'(w) - p;
            rl  = (EditW+1)'(n - e) + 1'b1;
            if (rem < (BaseW+1)'(rl)) rl = (EditW+1)'(rem);
         end
         if (rl == '0)
            r[int'(o) * EditSpan + int'(e) + 1] = 1'b1;
         else if (chi[0])
            r[(int'(o) + 1) * EditSpan + int'(e)] = 1'b1;
         else begin
            r[int'(o) * EditSpan + int'(e) + 1] = 1'b1;
            r[(int'(o) + 1) * EditSpan + int'(e) + 1] = 1'b1;
            for (int k = 1; k < Span; k++) begin
               if (!found && k < int'(rl) && chi[k]) begin
                  found = 1'b1;
                  if (int'(e) + k < EditSpan)
                     r[(int'(o) + k + 1) * EditSpan + int'(e) + k] = 1'b1;
               end
            end
         end
      end
      return r;
   endfunction

   // Subsumption test of one image entry against the whole image.
   function automatic logic subsumed(input logic [ImgBits-1:0] img,
      input logic [OffW-1:0] o, input logic [EditW-1:0] e);
      logic s;
      int d;
      s = 1'b0;
      for (int o2 = 0; o2 < ImgSpan; o2++)
         for (int e2 = 0; e2 < EditSpan; e2++) begin
            d = (o2 > int'(o)) ? o2 - int'(o) : int'(o) - o2;
            if (e2 < int'(e) && img[o2 * EditSpan + e2] && d <= int'(e) - e2)
               s = 1'b1;
         end
      return s;
   endfunction

   logic [OffW-1:0] lo;
   logic [SetBits-1:0] shifted;
   logic [BaseW+1:0] nb;
   always_comb begin
      lo = OffW'(ImgSpan);
      for (int o = ImgSpan - 1; o >= 0; o--)
         if (|keep_ff[o * EditSpan +: EditSpan]) lo = OffW'(o);
      shifted = '0;
      for (int o = 0; o < Span; o++)
         if (o + int'(lo) < ImgSpan)
            shifted[o * EditSpan +: EditSpan] =
               keep_ff[(o + int'(lo)) * EditSpan +: EditSpan];
      nb = (BaseW+2)'(base_ff) + (BaseW+2)'(lo);
   end

   logic acc_hit;
   assign acc_hit = set_ff[int'(po_ff) * EditSpan + int'(pe_ff)] &&
      ((BaseW+2)'(w_eff) + (BaseW+2)'(pe_ff) <=
       (BaseW+2)'(n_eff) + (BaseW+2)'(base_ff) + (BaseW+2)'(po_ff));

   logic chi_bit;
   assign chi_bit = (win_p < (BaseW+1)'(w_eff)) && (rd_ff == letter_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         nmax_ff  <= 2'd1;
         wlen_ff  <= '0;
         set_ff   <= SetBits'(1);
         base_ff  <= '0;
         dead_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            if (csr_index == CSR_MAX_EDITS) nmax_ff <= csr_wdata[1:0];
            else                            wlen_ff <= csr_wdata;
         end
         // Drop a taken status beat unless the output cycle refills it.
         if (rsp_valid_ff && rsp_tready && state_ff != S_OUT) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_tvalid) begin
               letter_ff <= cp;
               po_ff <= '0; pe_ff <= '0; wk_ff <= '0;
               img_ff <= '0; chi_ff <= '0; acc_ff <= 1'b0;
               if (cmd == CMD_RESTART) begin
                  set_ff <= SetBits'(1); base_ff <= '0; dead_ff <= 1'b0;
                  state_ff <= S_STAT;
               end else if (cmd == CMD_FEED && !dead_ff)
                  state_ff <= S_READ;
               else
                  state_ff <= S_STAT;
            end
            // Fill the window bits of the current offset, one RAM read per window slot.
            S_READ: state_ff <= S_STEP;
            S_STEP: begin
               chi_ff[wk_ff] <= chi_bit;
               if (int'(wk_ff) == Span - 1) begin
                  wk_ff <= '0;
                  state_ff <= S_PRUNE;
                  ko_ff <= '0; ke_ff <= '0; pe_ff <= '0;
               end else begin
                  wk_ff <= wk_ff + 1'b1;
                  state_ff <= S_READ;
               end
            end
            // Walk edits of this offset through the transition unit.
            S_PRUNE: begin
               if (set_ff[int'(po_ff) * EditSpan + int'(pe_ff)])
                  img_ff <= step_pos(img_ff, po_ff, pe_ff, chi_ff,
                                     base_ff, w_eff, n_eff);
               if (int'(pe_ff) == EditSpan - 1) begin
                  pe_ff <= '0;
                  if (int'(po_ff) == Span - 1) begin
                     po_ff <= '0;
                     keep_ff <= '0;
                     state_ff <= S_SHIFT;
                  end else begin
                     po_ff <= po_ff + 1'b1;
                     state_ff <= S_READ;
                  end
               end else pe_ff <= pe_ff + 1'b1;
            end
            // Prune one image entry a cycle, then shift by minimum offset.
            S_SHIFT: begin
               if (int'(ko_ff) < ImgSpan) begin
                  keep_ff[int'(ko_ff) * EditSpan + int'(ke_ff)] <=
                     img_ff[int'(ko_ff) * EditSpan + int'(ke_ff)] &&
                     !subsumed(img_ff, ko_ff, ke_ff);
                  if (int'(ke_ff) == EditSpan - 1) begin
                     ke_ff <= '0; ko_ff <= ko_ff + 1'b1;
                  end else ke_ff <= ke_ff + 1'b1;
               end else begin
                  if (int'(lo) == ImgSpan) begin
                     dead_ff <= 1'b1; set_ff <= '0;
                  end else begin
                     set_ff <= shifted;
                     base_ff <= (nb > 127) ? 7'd127 : nb[BaseW-1:0];
                  end
                  po_ff <= '0; pe_ff <= '0;
                  state_ff <= S_STAT;
               end
            end
            // Scan positions for the accept condition.
            S_STAT: begin
               if (acc_hit) acc_ff <= 1'b1;
               if (int'(pe_ff) == EditSpan - 1) begin
                  pe_ff <= '0;
                  if (int'(po_ff) == Span - 1) state_ff <= S_OUT;
                  else po_ff <= po_ff + 1'b1;
               end else pe_ff <= pe_ff + 1'b1;
            end
            S_OUT: if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= {7'd0, base_ff, acc_ff && !dead_ff, !dead_ff};
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_dead_empty: assert property (@(posedge clock) disable iff (reset)
      dead_ff |-> (set_ff == '0 || state_ff != S_IDLE)) else $error("dead set");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> $stable(rsp_data_ff)) else $error("rsp");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("busy");
   a_live_set: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !dead_ff) |-> set_ff != '0) else $error("empty");
`endif

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Levenshtein automaton step core: self-checking bench
// Loads patterns, restarts and feeds letters under several edit bounds and
// word lengths; a behavioural automaton predicts alive, accepting and base.
// ---------------------------------------------------------------------------
module tb;
   import lev_pkg::*;

   localparam int StallLimit = 5000;
   localparam int LongHold   = 400;

   typedef struct packed {
      logic       alive;
      logic       accepting;
      logic [6:0] base;
   } status_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_wen    = 1'b0;
   logic        csr_index  = 1'b0;
   logic [6:0]  csr_wdata  = '0;

   // automaton mirror
   logic [20:0] pattern_mem [MaxWord];
   bit          live_set [Span][EditSpan];
   bit          img_set [ImgSpan][EditSpan];
   int          base_idx;
   bit          is_dead;
   int          bound_n;
   int          word_w;

   status_type  status_q[$];
   int          errors;
   int          n_items;
   int          n_letters;
   int          n_accepting;
   bit          idle_on;
   bit          long_hold;
   int          quiet_cycles;

   levenshtein_automaton_step_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Automaton mirror
   // ---------------------------------------------------------------------
   function automatic bit letter_hit(int p, logic [20:0] l);
      return p < word_w && p < MaxWord && pattern_mem[p] == l;
   endfunction

   function automatic void mark_img(int o, int e);
      if (o < ImgSpan && e < EditSpan) img_set[o][e] = 1'b1;
   endfunction

   // Elementary transitions of one position under one letter
   function automatic void move_position(int o, int e, logic [20:0] l);
      int p;
      int reach;
      p = base_idx + o;
      reach = 0;
      // at or above the bound only a match survives
      if (e >= bound_n) begin
         if (letter_hit(p, l)) mark_img(o + 1, e);
         return;
      end
      if (p < word_w) begin
         reach = bound_n - e + 1;
         if (word_w - p < reach) reach = word_w - p;
      end
      if (reach == 0) begin
         mark_img(o, e + 1);
         return;
      end
      if (letter_hit(p, l)) begin
         mark_img(o + 1, e);
         return;
      end
      mark_img(o, e + 1);
      mark_img(o + 1, e + 1);
      for (int k = 1; k < reach; k++) begin
         if (letter_hit(p + k, l)) begin
            mark_img(o + k + 1, e + k);
            break;
         end
      end
   endfunction

   function automatic bit covered(int o, int e);
      int d;
      for (int o2 = 0; o2 < ImgSpan; o2++)
         for (int e2 = 0; e2 < e; e2++) begin
            if (!img_set[o2][e2]) continue;
            d = (o2 > o) ? o2 - o : o - o2;
            if (d <= e - e2) return 1'b1;
         end
      return 1'b0;
   endfunction

   function automatic void step_letter(logic [20:0] l);
      bit keep [ImgSpan][EditSpan];
      int lo;
      lo = ImgSpan;
      foreach (img_set[o, e]) img_set[o][e] = 1'b0;
      foreach (live_set[o, e]) if (live_set[o][e]) move_position(o, e, l);
      foreach (keep[o, e]) begin
         keep[o][e] = img_set[o][e] && !covered(o, e);
         if (keep[o][e] && o < lo) lo = o;
      end
      foreach (live_set[o, e]) live_set[o][e] = 1'b0;
      if (lo == ImgSpan) begin
         is_dead = 1'b1;
         return;
      end
      foreach (keep[o, e]) if (keep[o][e] && o - lo < Span) live_set[o - lo][e] = 1'b1;
      base_idx = (base_idx + lo > 127) ? 127 : base_idx + lo;
   endfunction

   function automatic void restart_set();
      foreach (live_set[o, e]) live_set[o][e] = 1'b0;
      live_set[0][0] = 1'b1;
      base_idx = 0;
      is_dead = 1'b0;
   endfunction

   function automatic status_type apply_item(logic [1:0] cmd, logic [5:0] idx, logic [20:0] cp);
      status_type s;
      case (cmd)
         CMD_LOAD:    pattern_mem[idx] = cp;
         CMD_RESTART: restart_set();
         CMD_FEED:    if (!is_dead) step_letter(cp);
         default: ;
      endcase
      s.alive = !is_dead;
      s.accepting = 1'b0;
      if (!is_dead)
         foreach (live_set[o, e])
            if (live_set[o][e] && word_w + e <= bound_n + base_idx + o) s.accepting = 1'b1;
      s.base = base_idx[6:0];
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   // Offer one beat, hold until taken, then log its expected status.
   task automatic send_item(logic [1:0] cmd, logic [5:0] idx, logic [20:0] cp);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, cp, idx, cmd};
      do @(posedge clock); while (!req_tready);
      status_q.insert(status_q.size(), apply_item(cmd, idx, cp));
      n_items++;
      if (cmd == CMD_FEED) n_letters++;
   endtask

   // Drop valid and wait for every outstanding status beat.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [6:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen   <= 1'b0;
      if (idx == CSR_MAX_EDITS) bound_n = val[1:0];
      else bound_n = bound_n;
      if (idx == CSR_WORD_LENGTH) word_w = (val > MaxWord) ? MaxWord : val;
   endtask

   task automatic set_mode(int n, int w);
      drain();
      write_csr(CSR_MAX_EDITS, 7'(n));
      write_csr(CSR_WORD_LENGTH, 7'(w));
   endtask

   function automatic logic [20:0] any_cp();
      return 21'($urandom_range(0, 1114111));
   endfunction

   // small alphabet so letters hit the pattern often
   function automatic logic [20:0] near_cp();
      return ($urandom_range(0, 15) == 0) ? any_cp() : 21'(97 + $urandom_range(0, 3));
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Fill the whole store so no letter ever reads an unwritten entry.
   task automatic test_fill_store();
      for (int i = 0; i < MaxWord; i++) send_item(CMD_LOAD, 6'(i), near_cp());
   endtask

   task automatic test_corners();
      send_item(CMD_FEED, 6'd0, 21'd97);          // empty pattern under reset settings
      send_item(CMD_LOAD, 6'd63, 21'h10FFFF);
      send_item(CMD_LOAD, 6'd0, 21'd0);
      send_item(CMD_LOAD, 6'd1, 21'h10FFFF);
      send_item(CMD_LOAD, 6'd2, 21'h0F0000);
      set_mode(0, 3);
      send_item(CMD_RESTART, 6'h3F, 21'h1FFFFF & 21'h10FFFF);
      send_item(CMD_FEED, 6'd0, 21'd0);
      send_item(CMD_FEED, 6'd0, 21'h10FFFF);
      send_item(CMD_FEED, 6'd0, 21'h0F0000);      // exact word, accepting
      send_item(CMD_FEED, 6'd0, 21'd5);           // past the end with no edits: dies
      send_item(CMD_FEED, 6'd0, 21'd0);           // dead stays dead
      send_item(CMD_RESTART, 6'd0, 21'd0);        // revive
      send_item(CMD_FEED, 6'd0, 21'd7);           // mismatch, bound 0
      set_mode(3, 3);
      send_item(CMD_RESTART, 6'd0, 21'd0);
      send_item(CMD_FEED, 6'd0, 21'd9);
      send_item(CMD_FEED, 6'd0, 21'd9);
      send_item(CMD_FEED, 6'd0, 21'd9);
      // lowered bound with positions carrying three edits
      set_mode(1, 3);
      send_item(CMD_FEED, 6'd0, 21'h0F0000);
      send_item(CMD_FEED, 6'd0, 21'd9);
      set_mode(3, 64);
      send_item(CMD_RESTART, 6'd0, 21'd0);
      send_item(CMD_FEED, 6'd0, 21'h10FFFF);      // jump across the window
   endtask

   // Well-formed words with random edits, plus some noise.
   task automatic run_words(int n, int w, int budget);
      int target;
      int j;
      int len;
      set_mode(n, w);
      for (int i = 0; i < w; i++) send_item(CMD_LOAD, 6'(i), near_cp());
      target = n_items + budget;
      while (n_items < target) begin
         send_item(CMD_RESTART, 6'($urandom), any_cp());
         j = 0;
         len = w + $urandom_range(0, 4);
         for (int k = 0; k < len && n_items < target; k++) begin
            case ($urandom_range(0, 11))
               0: send_item(CMD_FEED, 6'($urandom), near_cp());                 // substitute
               1: begin j += 2; send_item(CMD_FEED, 6'($urandom),
                        (j - 1 < w) ? pattern_mem[j - 1] : near_cp()); end     // skip one
               2: send_item(CMD_FEED, 6'($urandom), any_cp());                  // stray letter
               3: send_item(CMD_LOAD, 6'($urandom_range(0, 63)),
                            ($urandom_range(0, 1) == 0) ? near_cp() : any_cp());
               default: begin
                  send_item(CMD_FEED, 6'($urandom), (j < w) ? pattern_mem[j] : near_cp());
                  j++;
               end
            endcase
         end
      end
   endtask

   // Receiver stops for a long stretch while beats keep coming.
   task automatic test_backpressure();
      drain();
      long_hold = 1'b1;
      for (int i = 0; i < 12; i++)
         send_item(($urandom_range(0, 3) == 0) ? CMD_RESTART : CMD_FEED, 6'($urandom), near_cp());
   endtask

   // ---------------------------------------------------------------------
   // Status checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (status_q.size() == 0) begin
            $display("%0t: unexpected status beat %h", $realtime, rsp_tdata);
            errors++;
         end else begin
            want = status_q.pop_front();
            if (rsp_tdata[0] !== want.alive) begin
               $display("%0t: alive exp %0b got %0b", $realtime, want.alive, rsp_tdata[0]);
               errors++;
            end
            if (rsp_tdata[1] !== want.accepting) begin
               $display("%0t: accepting exp %0b got %0b", $realtime, want.accepting,
                        rsp_tdata[1]);
               errors++;
            end
            if (rsp_tdata[8:2] !== want.base) begin
               $display("%0t: base exp %0d got %0d", $realtime, want.base, rsp_tdata[8:2]);
               errors++;
            end
            if (want.accepting) n_accepting++;
         end
      end
   end

   // Receiver: random stalls, one long hold-off on request
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (LongHold) @(posedge clock);
            long_hold = 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(0, 20)) @(posedge clock);
         end
      end
   end

   // Watchdog: cycles with no beat moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == StallLimit) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      errors = 0;
      n_items = 0;
      n_letters = 0;
      n_accepting = 0;
      quiet_cycles = 0;
      long_hold = 1'b0;
      idle_on = 1'b1;
      bound_n = 1;
      word_w = 0;
      foreach (pattern_mem[i]) pattern_mem[i] = '0;
      restart_set();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill_store();
      test_corners();
      run_words(0, 1, 100);
      run_words(1, 8, 150);
      run_words(2, 16, 150);
      run_words(3, 64, 160);
      test_backpressure();
      run_words(3, 5, 120);
      run_words(2, 0, 60);
      run_words(1, 33, 150);
      run_words(0, 64, 100);
      drain();
      idle_on = 1'b0;
      run_words(3, 12, 160);
      drain();
      repeat (100) @(posedge clock);

      $display("tb: %0d beats sent, %0d letters, %0d accepting statuses,", n_items, n_letters,
               n_accepting);
      $display("tb: bounds 0..3 and word lengths 0..64 with stalls and a long hold-off");
      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

// ----- levenshtein_automaton_step_core.f -----
design/lev_pkg.sv
design/levenshtein_automaton_step_core.sv
tb/sv/tb.sv
